/* sv/ffa_pkg.sv */
// Shared constants, header word layout and controller/datapath interface types
// for the first-fit block allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int POOL_GRANULES   = 4096;
  localparam int HEADER_GRANULES = 4;
  localparam int GRANULE_BYTES   = 8;
  localparam int GB_SHIFT        = $clog2(GRANULE_BYTES);

  localparam int IDX_W   = $clog2(POOL_GRANULES);
  localparam int LEN_W   = $clog2(POOL_GRANULES + 1);
  localparam int SUM_W   = LEN_W + 1;
  localparam int HDR_W   = LEN_W + 2;
  localparam int CMD_W   = 2;
  localparam int BYTES_W = 16;
  localparam int OFF_W   = 15;
  localparam int STAT_W  = 2;
  localparam int NEED_W  = BYTES_W + 1;

  localparam int PTR_BASE = HEADER_GRANULES * GRANULE_BYTES;
  localparam int PTR_END  = POOL_GRANULES * GRANULE_BYTES;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESIZE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPTR   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTALLOC = 2'd3;

  typedef struct packed {
    logic             st;
    logic             tk;
    logic [LEN_W-1:0] ln;
  } hdr_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLEAR, OP_LOAD, OP_WALK0, OP_WALK, OP_FOUND, OP_PTR_RD, OP_PTR_TAKE,
    OP_GROW, OP_SPLIT, OP_SPLIT2, OP_RELOAD, OP_RELOAD2, OP_FREE, OP_ABS, OP_ABS2,
    OP_PREV, OP_PREV2, OP_PREV3, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] stat;
    logic              moved;
    logic              keep_res;
  } dp_cmd_t;

  typedef struct packed {
    logic             clr_last;
    logic [CMD_W-1:0] cmd;
    logic             bytes_zero;
    logic             off_zero;
    logic             need_big;
    logic             ptr_bad;
    logic             rd_taken;
    logic             rd_free;
    logic             fits_in_place;
    logic             ptr_nx_ok;
    logic             grow_fits;
    logic             walk_fit;
    logic             walk_stop;
    logic             do_split;
    logic             free_nx_ok;
    logic             prev_nx_ok;
    logic             old_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: controller plus datapath.
// Depends on ffa_pkg, ffa_ctrl and ffa_datapath.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low; its result appears for
// exactly one cycle with out_valid high and cannot be held off by the receiver.
// After reset the block stays busy while it clears the header memory. An allocate
// visits one block header per cycle on the chain walk, since the header memory is
// read once per cycle. A free merges the freed block with free neighbours on either
// side, and a resize that relocates runs an allocate followed by a free.
module first_fit_block_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffa_pkg::CMD_W-1:0]     in_command,
  input  logic [ffa_pkg::BYTES_W-1:0]   in_request_bytes,
  input  logic [ffa_pkg::OFF_W-1:0]     in_payload_offset,
  output logic                          out_valid,
  output logic [ffa_pkg::STAT_W-1:0]    out_status,
  output logic [ffa_pkg::OFF_W-1:0]     out_result_offset,
  output logic                          out_moved
);
  import ffa_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ffa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(dp_stat), .cmd(dp_cmd),
    .busy(busy), .out_valid(out_valid)
  );

  ffa_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(dp_cmd),
    .in_command(in_command), .in_request_bytes(in_request_bytes),
    .in_payload_offset(in_payload_offset), .stat(dp_stat),
    .out_status(out_status), .out_result_offset(out_result_offset),
    .out_moved(out_moved)
  );

endmodule

`default_nettype wire

/* sv/ffa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/ffa_datapath.sv */
// Allocator datapath: header and back-link memories, working registers and
// result registers, driven by micro-operations. Depends on ffa_pkg and ffa_ram.
`timescale 1ns / 1ps
`default_nettype none

module ffa_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ffa_pkg::dp_cmd_t                cmd,
  input  logic [ffa_pkg::CMD_W-1:0]       in_command,
  input  logic [ffa_pkg::BYTES_W-1:0]     in_request_bytes,
  input  logic [ffa_pkg::OFF_W-1:0]       in_payload_offset,
  output ffa_pkg::dp_stat_t               stat,
  output logic [ffa_pkg::STAT_W-1:0]      out_status,
  output logic [ffa_pkg::OFF_W-1:0]       out_result_offset,
  output logic                            out_moved
);
  import ffa_pkg::*;

  logic [IDX_W-1:0]  clr_r;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic              bzero_r, bzero_nxt;
  logic [IDX_W-1:0]  g_r, g_nxt, old_r, old_nxt, b_r, b_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt, blen_r, blen_nxt;
  logic              merged_r, merged_nxt;
  logic [OFF_W-1:0]  res_r, res_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              moved_r, moved_nxt;

  logic              h_we;
  logic [IDX_W-1:0]  h_wa, h_ra;
  hdr_t              h_wd, h_rd;
  logic              p_we;
  logic [IDX_W-1:0]  p_wa, p_wd, p_ra, p_rd;

  logic [BYTES_W:0]  rnd;
  logic [IDX_W-1:0]  idx;
  logic [SUM_W-1:0]  ptr_nx, walk_sum, after, free_nx, abs_after, prev_nx;
  logic [NEED_W-1:0] rem, n_sum;
  logic [LEN_W-1:0]  abs_len;
  logic [OFF_W-1:0]  res_calc;

  ffa_ram #(.WIDTH(HDR_W), .DEPTH(POOL_GRANULES)) u_hdr_ram (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata_r(h_rd)
  );

  ffa_ram #(.WIDTH(IDX_W), .DEPTH(POOL_GRANULES)) u_prev_ram (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata_r(p_rd)
  );

  assign rnd       = {1'b0, in_request_bytes} + (BYTES_W + 1)'(GRANULE_BYTES - 1);
  assign idx       = IDX_W'((32'(off_r) - 32'(PTR_BASE)) >> GB_SHIFT);
  assign ptr_nx    = SUM_W'(idx) + SUM_W'(h_rd.ln);
  assign walk_sum  = SUM_W'(g_r) + SUM_W'(h_rd.ln);
  assign after     = SUM_W'(g_r) + SUM_W'(len_r);
  assign free_nx   = SUM_W'(b_r) + SUM_W'(blen_r);
  assign abs_len   = LEN_W'(SUM_W'(blen_r) + SUM_W'(h_rd.ln));
  assign abs_after = SUM_W'(b_r) + SUM_W'(abs_len);
  assign prev_nx   = SUM_W'(b_r) + SUM_W'(h_rd.ln);
  assign rem       = NEED_W'(len_r) - need_r;
  assign n_sum     = NEED_W'(g_r) + need_r;
  assign res_calc  = OFF_W'((32'(g_r) + 32'(HEADER_GRANULES)) << GB_SHIFT);

  always_comb begin
    stat.clr_last      = (clr_r == IDX_W'(POOL_GRANULES - 1));
    stat.cmd           = cmd_r;
    stat.bytes_zero    = bzero_r;
    stat.off_zero      = (off_r == '0);
    stat.need_big      = (need_r > NEED_W'(POOL_GRANULES));
    stat.ptr_bad       = (32'(off_r) < 32'(PTR_BASE)) || (32'(off_r) >= 32'(PTR_END))
                         || (((32'(off_r) - 32'(PTR_BASE)) % GRANULE_BYTES) != 0);
    stat.rd_taken      = h_rd.st && h_rd.tk;
    stat.rd_free       = h_rd.st && !h_rd.tk;
    stat.fits_in_place = (need_r <= NEED_W'(h_rd.ln));
    stat.ptr_nx_ok     = (ptr_nx < SUM_W'(POOL_GRANULES));
    stat.grow_fits     = ((NEED_W'(len_r) + NEED_W'(h_rd.ln)) >= need_r);
    stat.walk_fit      = !h_rd.tk && (NEED_W'(h_rd.ln) >= need_r);
    stat.walk_stop     = (h_rd.ln == '0) || (walk_sum >= SUM_W'(POOL_GRANULES));
    stat.do_split      = (need_r < NEED_W'(len_r)) && (rem >= NEED_W'(HEADER_GRANULES + 1))
                         && (n_sum < NEED_W'(POOL_GRANULES));
    stat.free_nx_ok    = (free_nx < SUM_W'(POOL_GRANULES));
    stat.prev_nx_ok    = (prev_nx < SUM_W'(POOL_GRANULES));
    stat.old_zero      = (old_r == '0);
  end

  always_comb begin
    cmd_nxt    = cmd_r;
    off_nxt    = off_r;
    need_nxt   = need_r;
    bzero_nxt  = bzero_r;
    g_nxt      = g_r;
    old_nxt    = old_r;
    b_nxt      = b_r;
    len_nxt    = len_r;
    blen_nxt   = blen_r;
    merged_nxt = merged_r;
    res_nxt    = res_r;
    stat_nxt   = stat_r;
    moved_nxt  = moved_r;
    h_we       = 1'b0;
    h_wa       = g_r;
    h_wd       = '0;
    h_ra       = '0;
    p_we       = 1'b0;
    p_wa       = g_r;
    p_wd       = g_r;
    p_ra       = old_r;
    unique case (cmd.op)
      OP_NOP: begin
      end
      OP_CLEAR: begin
        h_we = 1'b1;
        h_wa = clr_r;
        if (clr_r == '0) begin
          h_wd = '{st: 1'b1, tk: 1'b0, ln: LEN_W'(POOL_GRANULES)};
        end
      end
      OP_LOAD: begin
        cmd_nxt   = in_command;
        off_nxt   = in_payload_offset;
        bzero_nxt = (in_request_bytes == '0);
        need_nxt  = NEED_W'(rnd >> GB_SHIFT) + NEED_W'(HEADER_GRANULES);
      end
      OP_WALK0: begin
        g_nxt = '0;
        h_ra  = '0;
      end
      OP_WALK: begin
        g_nxt = IDX_W'(walk_sum);
        h_ra  = IDX_W'(walk_sum);
      end
      OP_FOUND: begin
        len_nxt    = h_rd.ln;
        res_nxt    = res_calc;
        merged_nxt = 1'b0;
      end
      OP_PTR_RD: begin
        h_ra = idx;
      end
      OP_PTR_TAKE: begin
        old_nxt    = idx;
        g_nxt      = idx;
        b_nxt      = idx;
        len_nxt    = h_rd.ln;
        blen_nxt   = h_rd.ln;
        res_nxt    = off_r;
        merged_nxt = 1'b0;
        h_ra       = IDX_W'(ptr_nx);
      end
      OP_GROW: begin
        h_we       = 1'b1;
        h_wa       = IDX_W'(after);
        len_nxt    = LEN_W'(NEED_W'(len_r) + NEED_W'(h_rd.ln));
        merged_nxt = 1'b1;
      end
      OP_SPLIT: begin
        h_we = 1'b1;
        h_wa = g_r;
        h_wd = '{st: 1'b1, tk: 1'b1, ln: (stat.do_split ? LEN_W'(need_r) : len_r)};
        p_we = (after < SUM_W'(POOL_GRANULES)) && (stat.do_split || merged_r);
        p_wa = IDX_W'(after);
        p_wd = stat.do_split ? IDX_W'(n_sum) : g_r;
      end
      OP_SPLIT2: begin
        h_we = 1'b1;
        h_wa = IDX_W'(n_sum);
        h_wd = '{st: 1'b1, tk: 1'b0, ln: LEN_W'(rem)};
        p_we = 1'b1;
        p_wa = IDX_W'(n_sum);
        p_wd = g_r;
      end
      OP_RELOAD: begin
        h_ra = old_r;
      end
      OP_RELOAD2: begin
        b_nxt    = old_r;
        blen_nxt = h_rd.ln;
      end
      OP_FREE: begin
        h_we = 1'b1;
        h_wa = b_r;
        h_wd = '{st: 1'b1, tk: 1'b0, ln: blen_r};
        h_ra = IDX_W'(free_nx);
      end
      OP_ABS: begin
        h_we     = 1'b1;
        h_wa     = IDX_W'(free_nx);
        blen_nxt = abs_len;
        p_we     = (abs_after < SUM_W'(POOL_GRANULES));
        p_wa     = IDX_W'(abs_after);
        p_wd     = b_r;
      end
      OP_ABS2: begin
        h_we = 1'b1;
        h_wa = b_r;
        h_wd = '{st: 1'b1, tk: 1'b0, ln: blen_r};
      end
      OP_PREV: begin
        p_ra = old_r;
      end
      OP_PREV2: begin
        b_nxt = p_rd;
        h_ra  = p_rd;
      end
      OP_PREV3: begin
        blen_nxt = h_rd.ln;
        h_ra     = IDX_W'(prev_nx);
      end
      OP_FINISH: begin
        stat_nxt  = cmd.stat;
        moved_nxt = cmd.moved;
        if (!cmd.keep_res) begin
          res_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_r <= clr_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    off_r    <= off_nxt;
    need_r   <= need_nxt;
    bzero_r  <= bzero_nxt;
    g_r      <= g_nxt;
    old_r    <= old_nxt;
    b_r      <= b_nxt;
    len_r    <= len_nxt;
    blen_r   <= blen_nxt;
    merged_r <= merged_nxt;
    res_r    <= res_nxt;
    stat_r   <= stat_nxt;
    moved_r  <= moved_nxt;
  end

  assign out_status        = stat_r;
  assign out_result_offset = res_r;
  assign out_moved         = moved_r;

endmodule

`default_nettype wire

/* sv/ffa_ctrl.sv */
// Allocator controller: sequences the datapath through clearing, chain walks,
// splits and merges. Depends on ffa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ffa_pkg::dp_stat_t stat,
  output ffa_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);
  import ffa_pkg::*;

  typedef enum logic [20:0] {
    S_CLEAR   = 21'h000001,
    S_IDLE    = 21'h000002,
    S_DISP    = 21'h000004,
    S_PCHK    = 21'h000008,
    S_GROW    = 21'h000010,
    S_ALLOCM  = 21'h000020,
    S_WALK    = 21'h000040,
    S_SPLIT   = 21'h000080,
    S_SPLIT2  = 21'h000100,
    S_SEND    = 21'h000200,
    S_RELOAD2 = 21'h000400,
    S_FREE    = 21'h000800,
    S_ABSA    = 21'h001000,
    S_ABSAW   = 21'h002000,
    S_PREV    = 21'h004000,
    S_PREV2   = 21'h008000,
    S_PREV3   = 21'h010000,
    S_ABSB    = 21'h020000,
    S_ABSBW   = 21'h040000,
    S_FEND    = 21'h080000,
    S_DONE    = 21'h100000
  } state_t;

  state_t state_r, state_nxt;
  logic   move_r, move_nxt;

  always_comb begin
    state_nxt    = state_r;
    move_nxt     = move_r;
    cmd.op       = OP_NOP;
    cmd.stat     = ST_OK;
    cmd.moved    = 1'b0;
    cmd.keep_res = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          move_nxt  = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat.cmd == CMD_ALLOC || (stat.cmd == CMD_RESIZE && stat.off_zero)) begin
          if (stat.bytes_zero || stat.need_big) begin
            cmd.op    = OP_FINISH;
            cmd.stat  = ST_NOSPACE;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_WALK0;
            state_nxt = S_WALK;
          end
        end else if (stat.cmd == CMD_FREE && stat.off_zero) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_DONE;
        end else if (stat.cmd == CMD_FREE || stat.cmd == CMD_RESIZE) begin
          if (stat.ptr_bad) begin
            cmd.op    = OP_FINISH;
            cmd.stat  = ST_BADPTR;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_PTR_RD;
            state_nxt = S_PCHK;
          end
        end else begin
          cmd.op    = OP_FINISH;
          cmd.stat  = ST_NOSPACE;
          state_nxt = S_DONE;
        end
      end
      S_PCHK: begin
        if (!stat.rd_taken) begin
          cmd.op    = OP_FINISH;
          cmd.stat  = ST_NOTALLOC;
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_PTR_TAKE;
          priority if (stat.cmd == CMD_FREE || stat.bytes_zero) begin
            state_nxt = S_FREE;
          end else if (stat.fits_in_place) begin
            state_nxt = S_SPLIT;
          end else if (stat.ptr_nx_ok) begin
            state_nxt = S_GROW;
          end else begin
            state_nxt = S_ALLOCM;
          end
        end
      end
      S_GROW, S_ALLOCM: begin
        if (state_r == S_GROW && stat.rd_free && stat.grow_fits) begin
          cmd.op    = OP_GROW;
          state_nxt = S_SPLIT;
        end else if (stat.need_big) begin
          cmd.op    = OP_FINISH;
          cmd.stat  = ST_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_WALK0;
          move_nxt  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        priority if (stat.walk_fit) begin
          cmd.op    = OP_FOUND;
          state_nxt = S_SPLIT;
        end else if (stat.walk_stop) begin
          cmd.op    = OP_FINISH;
          cmd.stat  = ST_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_WALK;
        end
      end
      S_SPLIT: begin
        cmd.op    = OP_SPLIT;
        state_nxt = stat.do_split ? S_SPLIT2 : S_SEND;
      end
      S_SPLIT2: begin
        cmd.op    = OP_SPLIT2;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (move_r) begin
          cmd.op    = OP_RELOAD;
          state_nxt = S_RELOAD2;
        end else begin
          cmd.op       = OP_FINISH;
          cmd.keep_res = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_RELOAD2: begin
        cmd.op    = OP_RELOAD2;
        state_nxt = S_FREE;
      end
      S_FREE: begin
        cmd.op    = OP_FREE;
        state_nxt = stat.free_nx_ok ? S_ABSA : S_PREV;
      end
      S_ABSA: begin
        if (stat.rd_free) begin
          cmd.op    = OP_ABS;
          state_nxt = S_ABSAW;
        end else begin
          state_nxt = S_PREV;
        end
      end
      S_ABSAW: begin
        cmd.op    = OP_ABS2;
        state_nxt = S_PREV;
      end
      S_PREV: begin
        if (stat.old_zero) begin
          state_nxt = S_FEND;
        end else begin
          cmd.op    = OP_PREV;
          state_nxt = S_PREV2;
        end
      end
      S_PREV2: begin
        cmd.op    = OP_PREV2;
        state_nxt = S_PREV3;
      end
      S_PREV3: begin
        if (stat.rd_free && stat.prev_nx_ok) begin
          cmd.op    = OP_PREV3;
          state_nxt = S_ABSB;
        end else begin
          state_nxt = S_FEND;
        end
      end
      S_ABSB: begin
        if (stat.rd_free) begin
          cmd.op    = OP_ABS;
          state_nxt = S_ABSBW;
        end else begin
          state_nxt = S_FEND;
        end
      end
      S_ABSBW: begin
        cmd.op    = OP_ABS2;
        state_nxt = S_FEND;
      end
      S_FEND: begin
        cmd.op       = OP_FINISH;
        cmd.moved    = move_r;
        cmd.keep_res = move_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      move_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      move_r  <= move_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

`default_nettype wire

/* sv/ffa_checker.sv */
// Port-level checks on the first-fit block allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_block_allocator.
`timescale 1ns / 1ps
`default_nettype none

module ffa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [ffa_pkg::STAT_W-1:0] out_status,
  input logic [ffa_pkg::OFF_W-1:0]  out_result_offset,
  input logic                       out_moved
);
  import ffa_pkg::*;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe lasted more than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("request not held busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_result_offset == '0))
    else $error("failing result carries an offset");

  a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_moved) |-> (out_status == ST_OK && out_result_offset != '0))
    else $error("moved flag on a failing result");

endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (.*);

`default_nettype wire

/* test/first_fit_block_allocator_tb.sv */
// Self-checking testbench for first_fit_block_allocator: predicts each response
// with its own model of the block chain and checks responses in order.
// Depends on ffa_pkg and the first_fit_block_allocator RTL.
`timescale 1ns / 1ps

class alloc_scoreboard;
  localparam int NG = ffa_pkg::POOL_GRANULES;
  localparam int HG = ffa_pkg::HEADER_GRANULES;
  localparam int GB = ffa_pkg::GRANULE_BYTES;

  bit          is_start[NG];
  int unsigned blk_len[NG];
  bit          is_taken[NG];
  int unsigned prev_blk[NG];

  logic [1:0]  want_status[$];
  logic [14:0] want_offset[$];
  logic        want_moved[$];
  int          errors;
  int          checked;

  function new();
    for (int i = 0; i < NG; i++) begin
      is_start[i] = 0;
      blk_len[i] = 0;
      is_taken[i] = 0;
      prev_blk[i] = 0;
    end
    is_start[0] = 1;
    blk_len[0] = NG;
  endfunction

  function int unsigned granules_for(int unsigned nbytes);
    return (nbytes + GB - 1) / GB + HG;
  endfunction

  function void split_block(int unsigned g, int unsigned need);
    int unsigned rem;
    int unsigned n;
    if (need >= blk_len[g]) return;
    rem = blk_len[g] - need;
    if (rem < HG + 1) return;
    n = g + need;
    if (n >= NG) return;
    is_start[n] = 1;
    blk_len[n] = rem;
    is_taken[n] = 0;
    prev_blk[n] = g;
    if (n + rem < NG) prev_blk[n + rem] = n;
    blk_len[g] = need;
  endfunction

  function void merge_next(int unsigned g);
    int unsigned nx;
    nx = g + blk_len[g];
    if (nx >= NG || !is_start[nx] || is_taken[nx]) return;
    blk_len[g] += blk_len[nx];
    is_start[nx] = 0;
    blk_len[nx] = 0;
    if (g + blk_len[g] < NG) prev_blk[g + blk_len[g]] = g;
  endfunction

  function logic [1:0] grant(int unsigned nbytes, output int unsigned off);
    int unsigned need;
    int unsigned g;
    off = 0;
    if (nbytes == 0) return ffa_pkg::ST_NOSPACE;
    need = granules_for(nbytes);
    if (need > NG) return ffa_pkg::ST_NOSPACE;
    g = 0;
    while (g < NG) begin
      if (!is_taken[g] && blk_len[g] >= need) break;
      if (blk_len[g] == 0) begin
        g = NG;
        break;
      end
      g += blk_len[g];
    end
    if (g >= NG) return ffa_pkg::ST_NOSPACE;
    split_block(g, need);
    is_taken[g] = 1;
    off = (g + HG) * GB;
    return ffa_pkg::ST_OK;
  endfunction

  function void release_block(int unsigned g);
    int unsigned p;
    is_taken[g] = 0;
    merge_next(g);
    if (g != 0) begin
      p = prev_blk[g];
      if (p < NG && is_start[p] && !is_taken[p]) merge_next(p);
    end
  endfunction

  function logic [1:0] lookup(int unsigned off, output int unsigned g);
    g = 0;
    if (off < HG * GB || off >= NG * GB) return ffa_pkg::ST_BADPTR;
    if ((off - HG * GB) % GB != 0) return ffa_pkg::ST_BADPTR;
    g = (off - HG * GB) / GB;
    if (!is_start[g] || !is_taken[g]) return ffa_pkg::ST_NOTALLOC;
    return ffa_pkg::ST_OK;
  endfunction

  function bit is_live(int unsigned off);
    int unsigned g;
    return lookup(off, g) == ffa_pkg::ST_OK;
  endfunction

  function void note_request(logic [1:0] cmd, int unsigned nbytes, int unsigned off);
    logic [1:0]  st;
    int unsigned res;
    logic        mv;
    int unsigned g;
    int unsigned need;
    int unsigned ln;
    int unsigned nx;
    st = ffa_pkg::ST_NOSPACE;
    res = 0;
    mv = 0;
    if (cmd == ffa_pkg::CMD_ALLOC) begin
      st = grant(nbytes, res);
    end else if (cmd == ffa_pkg::CMD_FREE) begin
      if (off == 0) st = ffa_pkg::ST_OK;
      else begin
        st = lookup(off, g);
        if (st == ffa_pkg::ST_OK) release_block(g);
      end
    end else if (cmd == ffa_pkg::CMD_RESIZE) begin
      if (off == 0) st = grant(nbytes, res);
      else begin
        st = lookup(off, g);
        if (st == ffa_pkg::ST_OK) begin
          if (nbytes == 0) release_block(g);
          else begin
            need = granules_for(nbytes);
            ln = blk_len[g];
            nx = g + ln;
            if (need <= ln) begin
              split_block(g, need);
              res = off;
            end else if (nx < NG && is_start[nx] && !is_taken[nx] &&
                         ln + blk_len[nx] >= need) begin
              blk_len[g] = ln + blk_len[nx];
              is_start[nx] = 0;
              blk_len[nx] = 0;
              if (g + blk_len[g] < NG) prev_blk[g + blk_len[g]] = g;
              split_block(g, need);
              res = off;
            end else begin
              st = grant(nbytes, res);
              if (st == ffa_pkg::ST_OK) begin
                release_block(g);
                mv = 1;
              end
            end
          end
        end
      end
    end
    want_status.push_back(st);
    want_offset.push_back(res[14:0]);
    want_moved.push_back(mv);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task check_response(logic [1:0] st, logic [14:0] off, logic mv);
    logic [1:0]  es;
    logic [14:0] eo;
    logic        em;
    if (want_status.size() == 0) begin
      report("response with no request outstanding");
      return;
    end
    es = want_status.pop_front();
    eo = want_offset.pop_front();
    em = want_moved.pop_front();
    checked++;
    if (st !== es) report($sformatf("status %0d, expected %0d", st, es));
    if (off !== eo) report($sformatf("result_offset %0d, expected %0d", off, eo));
    if (mv !== em) report($sformatf("moved %0b, expected %0b", mv, em));
  endtask
endclass

module first_fit_block_allocator_tb;
  import ffa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              start = 0;
  logic              busy;
  logic [CMD_W-1:0]  in_command = CMD_ALLOC;
  logic [BYTES_W-1:0] in_request_bytes = '0;
  logic [OFF_W-1:0]  in_payload_offset = '0;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [OFF_W-1:0]  out_result_offset;
  logic              out_moved;

  alloc_scoreboard sb = new();
  int gap_pct;
  int live_offsets[$];
  logic [14:0] last_offset;

  first_fit_block_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_request_bytes(in_request_bytes),
    .in_payload_offset(in_payload_offset), .out_valid(out_valid),
    .out_status(out_status), .out_result_offset(out_result_offset),
    .out_moved(out_moved)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_response(out_status, out_result_offset, out_moved);
  end

  always @(posedge clk) if (rst_n && out_valid) last_offset <= out_result_offset;

  function int pick_live();
    int k;
    for (int i = live_offsets.size() - 1; i >= 0; i--)
      if (!sb.is_live(live_offsets[i])) live_offsets.delete(i);
    if (live_offsets.size() == 0) return 0;
    k = $urandom_range(live_offsets.size() - 1);
    return live_offsets[k];
  endfunction

  task random_request();
    int r;
    int nbytes;
    int off;
    r = $urandom_range(99);
    nbytes = ($urandom_range(19) == 0) ? $urandom_range(65535) :
             ($urandom_range(9) == 0) ? $urandom_range(4000, 30000) : $urandom_range(1, 600);
    if (r < 45) begin
      do_request(CMD_ALLOC, nbytes, 0);
    end else if (r < 75) begin
      off = ($urandom_range(9) == 0) ? $urandom_range(32767) : pick_live();
      do_request(CMD_FREE, 0, off);
    end else if (r < 95) begin
      off = ($urandom_range(9) == 0) ? $urandom_range(32767) : pick_live();
      if ($urandom_range(15) == 0) nbytes = 0;
      do_request(CMD_RESIZE, nbytes, off);
    end else begin
      do_request(CMD_UNKNOWN, $urandom_range(65535), $urandom_range(32767));
    end
  endtask

  task do_request(logic [1:0] cmd, int unsigned nbytes, int unsigned off);
    logic [14:0] got;
    send_only(cmd, nbytes, off);
    got = last_offset;
    if (got != 0 && sb.is_live(got)) live_offsets.push_back(got);
  endtask

  task send_only(logic [1:0] cmd, int unsigned nbytes, int unsigned off);
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    start <= 1;
    in_command <= cmd;
    in_request_bytes <= nbytes[15:0];
    in_payload_offset <= off[14:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(cmd, nbytes, off);
    start <= 0;
    while (sb.want_status.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    #50_000_000;
    $display("first_fit_block_allocator_tb: FAIL");
    $finish;
  end

  initial begin
    int a;
    int b;
    gap_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    do_request(CMD_ALLOC, 0, 0);
    do_request(CMD_ALLOC, 65535, 0);
    do_request(CMD_ALLOC, 32736, 0);
    a = last_offset;
    do_request(CMD_FREE, 0, a);
    do_request(CMD_ALLOC, 1, 0);
    a = last_offset;
    do_request(CMD_ALLOC, 100, 0);
    b = last_offset;
    do_request(CMD_ALLOC, 8, 0);
    do_request(CMD_FREE, 0, 0);
    do_request(CMD_FREE, 0, 31);
    do_request(CMD_FREE, 0, 33);
    do_request(CMD_FREE, 0, 32767);
    do_request(CMD_FREE, 0, 32768 - 8);
    do_request(CMD_FREE, 0, b + 16);
    do_request(CMD_RESIZE, 200, 0);
    do_request(CMD_RESIZE, 20, b);
    do_request(CMD_RESIZE, 300, b);
    do_request(CMD_RESIZE, 2000, a);
    do_request(CMD_RESIZE, 70000 - 65536, b);
    do_request(CMD_RESIZE, 65535, last_offset);
    do_request(CMD_RESIZE, 0, b);
    do_request(CMD_FREE, 0, b);
    do_request(CMD_UNKNOWN, 65535, 32767);
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 6 : (ph == 1) ? 55 : 0;
      repeat (300) random_request();
    end
    repeat (20) @(posedge clk);
    $display("Covered %0d responses: directed corner cases plus random allocate,",
             sb.checked);
    $display("free and resize traffic under three sender idle settings.");
    if (sb.errors == 0 && sb.want_status.size() == 0) begin
      $display("first_fit_block_allocator_tb: PASS");
    end else begin
      $display("first_fit_block_allocator_tb: FAIL");
    end
    $finish;
  end
endmodule
